// ===== sv/clpr_pkg.sv =====
// package for the case link packet responder
// holds beat types, the queue entry, command and result codes
// no dependencies
package clpr_pkg;

    // input beat: one received packet plus local status
    typedef struct packed {
        logic [7:0] rx_header;
        logic [7:0] rx_byte1;
        logic [7:0] rx_byte2;
        logic [7:0] battery_level;
        logic [1:0] pairing_status;
    } t_in;

    // output beat: one result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  reply_byte0;
        logic [7:0]  reply_byte1;
        logic [7:0]  reply_byte2;
        logic [63:0] payload;
        logic        last;
    } t_out;

    // queue entry: optional notification followed by the reply
    typedef struct packed {
        logic        has_note;
        logic [2:0]  note_kind;
        logic [63:0] note_payload;
        logic [7:0]  reply_b0;
        logic [7:0]  reply_b1;
        logic [7:0]  reply_b2;
    } t_job;

    // configuration register indexes
    localparam logic [1:0] CFG_EAR_SIDE   = 2'd0;
    localparam logic [1:0] CFG_LOCAL_ADDR = 2'd1;
    localparam logic [1:0] CFG_LOCAL_VER  = 2'd2;
    localparam logic [1:0] CFG_IMAGE_VER  = 2'd3;

    // result kinds
    localparam logic [2:0] K_REPLY       = 3'd0;
    localparam logic [2:0] K_CASE_STATUS = 3'd1;
    localparam logic [2:0] K_CASE_BATT   = 3'd2;
    localparam logic [2:0] K_PEER_ADDR   = 3'd3;
    localparam logic [2:0] K_PEER_VER    = 3'd4;
    localparam logic [2:0] K_CASE_VER    = 3'd5;

    // packet types
    localparam logic [1:0] PT_START  = 2'd0;
    localparam logic [1:0] PT_DATA   = 2'd1;
    localparam logic [1:0] PT_END    = 2'd2;
    localparam logic [1:0] PT_RESEND = 2'd3;

    // ear codes
    localparam logic [1:0] EAR_LEFT  = 2'd1;
    localparam logic [1:0] EAR_RIGHT = 2'd2;

    // commands
    localparam logic [3:0] CMD_TEST       = 4'd0;
    localparam logic [3:0] CMD_GET_ADDR   = 4'd1;
    localparam logic [3:0] CMD_PEER_ADDR  = 4'd2;
    localparam logic [3:0] CMD_GET_VER    = 4'd3;
    localparam logic [3:0] CMD_PEER_VER   = 4'd4;
    localparam logic [3:0] CMD_CASE_VER   = 4'd5;
    localparam logic [3:0] CMD_CASE_BATT  = 4'd6;
    localparam logic [3:0] CMD_OWN_BATT   = 4'd7;
    localparam logic [3:0] CMD_EVENT      = 4'd8;
    localparam logic [3:0] CMD_UPGRADE    = 4'd9;
    localparam logic [3:0] CMD_STATUS     = 4'd10;

    // result queue depth
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

endpackage

// ===== sv/clpr_front.sv =====
// front end: accepts packets, filters the ear, decodes the command,
// updates collected words and builds the queue entry; uses clpr_pkg
module clpr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_wdata,
    input  logic              i_in_valid,
    input  clpr_pkg::t_in     i_in_data,
    output logic              o_in_stall,
    input  logic              i_full,
    output logic              o_push,
    output clpr_pkg::t_job    o_job
);
    import clpr_pkg::*;

    // read one 16-bit pair of a word
    function automatic logic [15:0] get_pair(input logic [63:0] w, input logic [1:0] idx);
        logic [15:0] r;
        r = 16'd0;
        for (int k = 0; k < 4; k++) begin
            if (idx == k[1:0]) r = w[16*k +: 16];
        end
        return r;
    endfunction

    // replace one 16-bit pair of a word
    function automatic logic [63:0] set_pair(input logic [63:0] w, input logic [1:0] idx,
                                             input logic [15:0] d);
        logic [63:0] r;
        r = w;
        for (int k = 0; k < 4; k++) begin
            if (idx == k[1:0]) r[16*k +: 16] = d;
        end
        return r;
    endfunction

    // configuration
    logic        r_ear_side;
    logic [47:0] r_local_addr;
    logic [63:0] r_local_ver;
    logic [31:0] r_image_ver;

    // collected state
    logic [47:0] r_peer_addr,    n_peer_addr;
    logic [63:0] r_peer_ver,     n_peer_ver;
    logic [63:0] r_case_ver,     n_case_ver;
    logic [2:0]  r_addr_off,     n_addr_off;
    logic [2:0]  r_pver_off,     n_pver_off;
    logic [2:0]  r_cver_off,     n_cver_off;
    logic        r_need_upgrade, n_need_upgrade;

    logic       accept;
    logic [1:0] ear;
    logic [3:0] cmd;
    logic [1:0] ptype;
    logic [7:0] d1, d2;
    logic       match;
    logic [1:0] rd_idx3, rd_idx4;
    logic [1:0] wr_addr_idx, wr_pver_idx, wr_cver_idx;
    logic [15:0] wr_data;
    logic [15:0] rd_addr_pair, rd_ver_pair;
    logic [1:0] cap, lid;
    logic [6:0] press_len;
    logic [7:0] ears;
    logic       key_short, key_long;
    t_job       job;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    // header fields
    assign ear   = i_in_data.rx_header[7:6];
    assign cmd   = i_in_data.rx_header[5:2];
    assign ptype = i_in_data.rx_header[1:0];
    assign d1    = i_in_data.rx_byte1;
    assign d2    = i_in_data.rx_byte2;
    assign match = (ear == (r_ear_side ? EAR_RIGHT : EAR_LEFT));

    // read index, out-of-range requests fall back to pair 0
    assign rd_idx3 = (d1 > 8'd2) ? 2'd0 : d1[1:0];
    assign rd_idx4 = (d1 > 8'd3) ? 2'd0 : d1[1:0];
    assign rd_addr_pair = get_pair({16'd0, r_local_addr}, rd_idx3);
    assign rd_ver_pair  = get_pair(r_local_ver, rd_idx4);

    // write index, an offset past the last pair restarts at pair 0
    assign wr_addr_idx = (r_addr_off > 3'd2) ? 2'd0 : r_addr_off[1:0];
    assign wr_pver_idx = (r_pver_off > 3'd3) ? 2'd0 : r_pver_off[1:0];
    assign wr_cver_idx = (r_cver_off > 3'd3) ? 2'd0 : r_cver_off[1:0];
    assign wr_data     = {d2, d1};

    // lid, key and ear event decode; mask bits 5:4 always set, value bits 1:0
    assign cap       = d1[7:6];
    assign lid       = (cap == 2'd1 || cap == 2'd2) ? cap : 2'd0;
    assign press_len = d2[6:0];
    assign key_short = (press_len >= 7'd3) && (press_len < 7'd9);
    assign key_long  = (press_len >= 7'd10);
    assign ears      = {2'b00, 2'b11, 2'b00, d1[4], d1[5]};

    // command decode and state update
    always_comb begin
        n_peer_addr    = r_peer_addr;
        n_peer_ver     = r_peer_ver;
        n_case_ver     = r_case_ver;
        n_addr_off     = r_addr_off;
        n_pver_off     = r_pver_off;
        n_cver_off     = r_cver_off;
        n_need_upgrade = r_need_upgrade;
        job            = '0;
        job.reply_b0   = i_in_data.rx_header;
        case (cmd)
            CMD_TEST: begin
            end
            CMD_GET_ADDR: begin
                if (ptype == PT_DATA) begin
                    job.reply_b1 = rd_addr_pair[7:0];
                    job.reply_b2 = rd_addr_pair[15:8];
                end
            end
            CMD_PEER_ADDR: begin
                if (ptype == PT_END) begin
                    job.has_note     = 1'b1;
                    job.note_kind    = K_PEER_ADDR;
                    job.note_payload = {16'd0, r_peer_addr};
                end
                if (ptype == PT_START || ptype == PT_END) begin
                    n_addr_off = 3'd0;
                end else if (ptype == PT_DATA) begin
                    n_peer_addr  = 48'(set_pair({16'd0, r_peer_addr}, wr_addr_idx, wr_data));
                    job.reply_b1 = {6'd0, wr_addr_idx};
                    n_addr_off   = {1'b0, wr_addr_idx} + 3'd1;
                end
            end
            CMD_GET_VER: begin
                if (ptype == PT_DATA) begin
                    job.reply_b1 = rd_ver_pair[7:0];
                    job.reply_b2 = rd_ver_pair[15:8];
                end
            end
            CMD_PEER_VER: begin
                if (ptype == PT_END) begin
                    job.has_note     = 1'b1;
                    job.note_kind    = K_PEER_VER;
                    job.note_payload = r_peer_ver;
                end
                if (ptype == PT_START || ptype == PT_END) begin
                    n_pver_off = 3'd0;
                end else if (ptype == PT_DATA) begin
                    n_peer_ver   = set_pair(r_peer_ver, wr_pver_idx, wr_data);
                    job.reply_b1 = {6'd0, wr_pver_idx};
                    n_pver_off   = {1'b0, wr_pver_idx} + 3'd1;
                end
            end
            CMD_CASE_VER: begin
                if (ptype == PT_END) begin
                    n_need_upgrade   = (r_case_ver[63:32] != r_image_ver);
                    job.has_note     = 1'b1;
                    job.note_kind    = K_CASE_VER;
                    job.note_payload = r_case_ver;
                end
                if (ptype == PT_START || ptype == PT_END) begin
                    n_cver_off = 3'd0;
                end else if (ptype == PT_DATA) begin
                    n_case_ver   = set_pair(r_case_ver, wr_cver_idx, wr_data);
                    job.reply_b1 = {6'd0, wr_cver_idx};
                    n_cver_off   = {1'b0, wr_cver_idx} + 3'd1;
                end
            end
            CMD_CASE_BATT: begin
                job.has_note     = 1'b1;
                job.note_kind    = K_CASE_BATT;
                job.note_payload = {56'd0, d1};
            end
            CMD_OWN_BATT: begin
                job.reply_b1 = i_in_data.battery_level;
            end
            CMD_EVENT: begin
                job.has_note  = 1'b1;
                job.note_kind = K_CASE_STATUS;
                job.note_payload[1:0] = lid;
                if (d2[7]) begin
                    job.note_payload[2]    = key_short;
                    job.note_payload[3]    = key_long && !key_short;
                    job.note_payload[15:8] = ears;
                end
            end
            CMD_UPGRADE: begin
                if (ptype == PT_END) n_need_upgrade = 1'b0;
            end
            CMD_STATUS: begin
                job.reply_b1 = {i_in_data.pairing_status, 2'b01, r_need_upgrade, 3'b000};
                job.reply_b2 = i_in_data.battery_level;
            end
            default: begin
                job.reply_b0 = 8'd0;
            end
        endcase
    end

    assign o_push = accept && match;
    assign o_job  = job;

    // configuration and collected state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ear_side     <= 1'b0;
            r_local_addr   <= '0;
            r_local_ver    <= '0;
            r_image_ver    <= '0;
            r_peer_addr    <= 48'h0100_0015_1413;
            r_peer_ver     <= '0;
            r_case_ver     <= '0;
            r_addr_off     <= '0;
            r_pver_off     <= '0;
            r_cver_off     <= '0;
            r_need_upgrade <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_EAR_SIDE:   r_ear_side   <= i_cfg_wdata[0];
                    CFG_LOCAL_ADDR: r_local_addr <= i_cfg_wdata[47:0];
                    CFG_LOCAL_VER:  r_local_ver  <= i_cfg_wdata;
                    CFG_IMAGE_VER:  r_image_ver  <= i_cfg_wdata[31:0];
                    default: begin
                    end
                endcase
            end
            if (o_push) begin
                r_peer_addr    <= n_peer_addr;
                r_peer_ver     <= n_peer_ver;
                r_case_ver     <= n_case_ver;
                r_addr_off     <= n_addr_off;
                r_pver_off     <= n_pver_off;
                r_cver_off     <= n_cver_off;
                r_need_upgrade <= n_need_upgrade;
            end
        end
    end

endmodule

// ===== sv/clpr_queue.sv =====
// short queue of decoded entries between front and back end
// uses clpr_pkg for the entry type and depth
module clpr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  clpr_pkg::t_job    i_job,
    output logic              o_full,
    output logic              o_valid,
    output clpr_pkg::t_job    o_head,
    input  logic              i_pop
);
    import clpr_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;
    logic           do_pop;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/clpr_back.sv =====
// back end: turns a queue entry into one or two output beats
// holds the output register; uses clpr_pkg
module clpr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  clpr_pkg::t_job    i_job,
    output logic              o_pop,
    output logic              o_out_valid,
    output clpr_pkg::t_out    o_out_data,
    input  logic              i_out_stall
);
    import clpr_pkg::*;

    t_job r_job;
    logic r_busy;
    logic r_note;
    logic beat_done;
    logic reply_done;

    assign beat_done  = r_busy && !i_out_stall;
    assign reply_done = beat_done && !r_note;
    assign o_pop      = i_valid && (!r_busy || reply_done);

    // output beat from the held entry
    always_comb begin
        o_out_valid = r_busy;
        o_out_data  = '0;
        if (r_note) begin
            o_out_data.kind    = r_job.note_kind;
            o_out_data.payload = r_job.note_payload;
        end else begin
            o_out_data.kind        = K_REPLY;
            o_out_data.reply_byte0 = r_job.reply_b0;
            o_out_data.reply_byte1 = r_job.reply_b1;
            o_out_data.reply_byte2 = r_job.reply_b2;
            o_out_data.last        = 1'b1;
        end
    end

    // entry register and beat sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_note <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_note <= i_job.has_note;
        end else if (reply_done) begin
            r_busy <= 1'b0;
        end else if (beat_done) begin
            r_note <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
    end

endmodule

// ===== sv/case_link_packet_responder_top.sv =====
// top level of the case link packet responder
// connects front end, entry queue and back end; uses clpr_pkg
//
//  channel  | valid       | stall        | beat
//  ---------+-------------+--------------+------------------------------
//  in       | i_in_valid  | o_in_stall   | i_in_data  (packet + status)
//  out      | o_out_valid | i_out_stall  | o_out_data (one result)
//  cfg      | i_cfg_we    | -            | i_cfg_index, i_cfg_wdata
//
// one packet is taken per cycle while the queue is not full; it is decoded and
// its state updated at accept, and its results reach the output through the queue
// and the back-end entry register; the output gives one beat per cycle while not stalled,
// so a packet with a notification uses two output beats (notification, then reply) and one without uses one
// the four-entry queue lets input keep flowing while the output is stalled;
// o_in_stall rises only when the queue is full
// synchronous active-low reset clears queue pointers, offsets and config and presets the collected words
module case_link_packet_responder_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_wdata,
    input  logic              i_in_valid,
    input  clpr_pkg::t_in     i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output clpr_pkg::t_out    o_out_data,
    input  logic              i_out_stall
);
    import clpr_pkg::*;

    logic q_push, q_full, q_valid, q_pop;
    t_job q_in_job, q_head;

    // decode and state
    clpr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_job       (q_in_job)
    );

    // decoupling queue
    clpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    // result sequencing
    clpr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_job       (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== bench/tb.sv =====
// testbench for case_link_packet_responder_top: directed table then random packet sequences
// predicts answers and notifications in-bench and checks every output beat in order
// depends on clpr_pkg and the responder rtl
module tb;
    import clpr_pkg::*;

    // codes with no name in the package
    localparam logic [1:0] EAR_NONE         = 2'd0;
    localparam logic [1:0] EAR_BOTH         = 2'd3;
    localparam logic [3:0] CMD_FIRST_UNUSED = 4'd11;
    localparam logic [3:0] CMD_LAST_UNUSED  = 4'd15;

    localparam int N_DIR      = 25;
    localparam int N_SETTINGS = 5;
    localparam int PER_PHASE  = 350;

    // directed row: packet plus an optional reply typed in by hand
    typedef struct {
        t_in         pk;
        bit          typed;
        bit          silent;
        logic [23:0] reply;
    } t_dir_row;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_wdata;
    logic        in_valid;
    t_in         in_data;
    logic        in_stall;
    logic        out_valid;
    t_out        out_data;
    logic        out_stall = 1'b0;

    // register mirror
    logic        cfg_side;
    logic [47:0] cfg_addr;
    logic [63:0] cfg_ver;
    logic [31:0] cfg_img;

    // collected words and offsets as the block should hold them
    logic [47:0] peer_addr;
    logic [63:0] peer_ver;
    logic [63:0] case_ver;
    logic [2:0]  addr_off;
    logic [2:0]  peer_ver_off;
    logic [2:0]  case_ver_off;
    logic        need_up;

    t_out     pending_answers[$];
    t_out     want;
    t_dir_row dir_tab[N_DIR];

    int  errors        = 0;
    int  beats_checked = 0;
    int  notes_checked = 0;
    int  own_items     = 0;
    int  all_items     = 0;
    int  gap_pct       = 0;
    int  stall_pct     = 0;
    int  out_hold      = 0;
    bit  no_idle       = 1'b0;

    case_link_packet_responder_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [1:0] own_ear();
        return cfg_side ? EAR_RIGHT : EAR_LEFT;
    endfunction

    function automatic t_in mk(logic [1:0] ear, logic [3:0] cmd, logic [1:0] pt,
                               logic [7:0] d1, logic [7:0] d2, logic [7:0] batt,
                               logic [1:0] pst);
        t_in p;
        p.rx_header      = {ear, cmd, pt};
        p.rx_byte1       = d1;
        p.rx_byte2       = d2;
        p.battery_level  = batt;
        p.pairing_status = pst;
        return p;
    endfunction

    // same, with random battery and pairing state
    function automatic t_in mkr(logic [1:0] ear, logic [3:0] cmd, logic [1:0] pt,
                                logic [7:0] d1, logic [7:0] d2);
        return mk(ear, cmd, pt, d1, d2, 8'($urandom_range(0, 255)),
                  2'($urandom_range(0, 3)));
    endfunction

    // pair read from a stored word, out-of-range index falls back to pair 0
    task automatic read_pair(input logic [1:0] pt, input logic [7:0] req,
                             input logic [63:0] word, input int pairs,
                             output logic [7:0] b1, output logic [7:0] b2);
        int idx;
        b1 = 8'h00;
        b2 = 8'h00;
        if (pt == PT_DATA) begin
            idx = req;
            if (idx > pairs - 1)
                idx = 0;
            b1 = word[16*idx +: 8];
            b2 = word[16*idx+8 +: 8];
        end
    endtask

    // pair write into a collected word; start and end rewind the offset
    task automatic write_pair(input logic [1:0] pt, input logic [7:0] d1,
                              input logic [7:0] d2, inout logic [63:0] word,
                              inout logic [2:0] off, input int pairs,
                              output logic [7:0] b1);
        b1 = 8'h00;
        if (pt == PT_START || pt == PT_END) begin
            off = 3'd0;
        end else if (pt == PT_DATA) begin
            if (off > pairs - 1)
                off = 3'd0;
            word[16*off +: 16] = {d2, d1};
            b1  = {5'd0, off};
            off = off + 3'd1;
        end
    endtask

    // expected beats for one accepted packet, state updated as the block does
    task automatic answer_packet(input t_in pk);
        logic [1:0]  ear, pt, cap;
        logic [3:0]  cmd;
        logic [7:0]  d1, d2, b0, b1, b2, ears;
        logic [6:0]  press_len;
        logic [63:0] word, note;
        logic [2:0]  note_kind;
        bit          has_note;
        t_out        r;
        ear       = pk.rx_header[7:6];
        cmd       = pk.rx_header[5:2];
        pt        = pk.rx_header[1:0];
        d1        = pk.rx_byte1;
        d2        = pk.rx_byte2;
        b0        = pk.rx_header;
        b1        = 8'h00;
        b2        = 8'h00;
        note      = 64'h0;
        note_kind = K_REPLY;
        has_note  = 1'b0;
        if (ear != own_ear())
            return;
        case (cmd)
            CMD_TEST: begin
            end
            CMD_GET_ADDR: begin
                read_pair(pt, d1, {16'h0, cfg_addr}, 3, b1, b2);
            end
            CMD_PEER_ADDR: begin
                if (pt == PT_END) begin
                    has_note  = 1'b1;
                    note_kind = K_PEER_ADDR;
                    note      = {16'h0, peer_addr};
                end
                word = {16'h0, peer_addr};
                write_pair(pt, d1, d2, word, addr_off, 3, b1);
                peer_addr = word[47:0];
            end
            CMD_GET_VER: begin
                read_pair(pt, d1, cfg_ver, 4, b1, b2);
            end
            CMD_PEER_VER: begin
                if (pt == PT_END) begin
                    has_note  = 1'b1;
                    note_kind = K_PEER_VER;
                    note      = peer_ver;
                end
                write_pair(pt, d1, d2, peer_ver, peer_ver_off, 4, b1);
            end
            CMD_CASE_VER: begin
                if (pt == PT_END) begin
                    need_up   = (case_ver[63:32] != cfg_img);
                    has_note  = 1'b1;
                    note_kind = K_CASE_VER;
                    note      = case_ver;
                end
                write_pair(pt, d1, d2, case_ver, case_ver_off, 4, b1);
            end
            CMD_CASE_BATT: begin
                has_note  = 1'b1;
                note_kind = K_CASE_BATT;
                note      = {56'h0, d1};
            end
            CMD_OWN_BATT: begin
                b1 = pk.battery_level;
            end
            CMD_EVENT: begin
                has_note  = 1'b1;
                note_kind = K_CASE_STATUS;
                cap       = d1[7:6];
                if (cap == 2'd1 || cap == 2'd2)
                    note[1:0] = cap;
                // key event: press length and ear mask/value bits
                if (d2[7]) begin
                    press_len = d2[6:0];
                    if (press_len >= 7'd3 && press_len < 7'd9)
                        note[2] = 1'b1;
                    else if (press_len >= 7'd10)
                        note[3] = 1'b1;
                    ears       = 8'h30 | {6'd0, d1[4], d1[5]};
                    note[15:8] = ears;
                end
            end
            CMD_UPGRADE: begin
                if (pt == PT_END)
                    need_up = 1'b0;
            end
            CMD_STATUS: begin
                b1 = {pk.pairing_status, 2'b01, need_up, 3'b000};
                b2 = pk.battery_level;
            end
            default: begin
                b0 = 8'h00;
            end
        endcase
        if (has_note) begin
            r             = '0;
            r.kind        = note_kind;
            r.payload     = note;
            pending_answers.push_back(r);
        end
        r             = '0;
        r.kind        = K_REPLY;
        r.reply_byte0 = b0;
        r.reply_byte1 = b1;
        r.reply_byte2 = b2;
        r.last        = 1'b1;
        pending_answers.push_back(r);
    endtask

    // drive one packet beat and wait for it to be taken
    task automatic send(input t_in pk, input bit typed = 1'b0, input bit silent = 1'b0,
                        input logic [23:0] reply = 24'h0);
        int   base;
        t_out r;
        if (!no_idle && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= pk;
        do @(posedge clk); while (in_stall);
        all_items++;
        if (pk.rx_header[7:6] == own_ear())
            own_items++;
        base = pending_answers.size();
        answer_packet(pk);
        // hand-typed rows replace what was just predicted
        if (typed) begin
            while (pending_answers.size() > base)
                void'(pending_answers.pop_back());
            if (!silent) begin
                r             = '0;
                r.kind        = K_REPLY;
                r.reply_byte0 = reply[23:16];
                r.reply_byte1 = reply[15:8];
                r.reply_byte2 = reply[7:0];
                r.last        = 1'b1;
                pending_answers.push_back(r);
            end
        end
    endtask

    task automatic cfg_write(input logic [1:0] index, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
        case (index)
            CFG_EAR_SIDE:   cfg_side = value[0];
            CFG_LOCAL_ADDR: cfg_addr = value[47:0];
            CFG_LOCAL_VER:  cfg_ver  = value;
            CFG_IMAGE_VER:  cfg_img  = value[31:0];
            default: begin
            end
        endcase
    endtask

    // wait out all expected beats, then let packets with no answer drain too
    task automatic settle();
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // one random sequence: mostly well-formed exchanges, some noise and broken ones
    task automatic run_sequence();
        int         r, n, k;
        bit         match_img;
        logic [1:0] ear, pt;
        logic [3:0] cmd;
        logic [7:0] d1, d2;
        r   = $urandom_range(0, 99);
        ear = own_ear();
        if (no_idle) begin
            gap_pct   = 0;
            stall_pct = 0;
        end else begin
            gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        end
        case ($urandom_range(0, 2))
            0: cmd = CMD_PEER_ADDR;
            1: cmd = CMD_PEER_VER;
            default: cmd = CMD_CASE_VER;
        endcase
        if (r < 10) begin
            // noise: any header at all
            send(mkr(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                     2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255))));
        end else if (r < 18) begin
            // broken collection: packet types in any order
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++)
                send(mkr(ear, cmd, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255))));
        end else if (r < 50) begin
            // well-formed collection, sometimes running past the last pair
            match_img = ($urandom_range(0, 1) == 1);
            send(mkr(ear, cmd, PT_START, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255))));
            n = $urandom_range(1, 5);
            for (k = 0; k < n; k++) begin
                d1 = 8'($urandom_range(0, 255));
                d2 = 8'($urandom_range(0, 255));
                if (cmd == CMD_CASE_VER && match_img && (k == 2 || k == 3)) begin
                    d1 = cfg_img[16*(k-2) +: 8];
                    d2 = cfg_img[16*(k-2)+8 +: 8];
                end
                send(mkr(ear, cmd, PT_DATA, d1, d2));
            end
            send(mkr(ear, cmd, PT_END, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255))));
            if (cmd == CMD_CASE_VER)
                send(mkr(ear, CMD_STATUS, 2'($urandom_range(0, 3)), 8'h00, 8'h00));
        end else if (r < 65) begin
            // reads of own address or version, now and then out of range
            cmd = ($urandom_range(0, 1) == 1) ? CMD_GET_ADDR : CMD_GET_VER;
            n   = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
                d1 = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'(k);
                pt = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3)) : PT_DATA;
                send(mkr(ear, cmd, pt, d1, 8'($urandom_range(0, 255))));
            end
        end else begin
            // single packet of any command for this side
            send(mkr(ear, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
        end
    endtask

    task automatic report_miss(input string what, input t_out exp_b, input t_out got);
        errors++;
        if (errors <= 10)
            $display("%0t %s: want kind %0d b %h %h %h payload %h last %b,",
                     $time, what, exp_b.kind, exp_b.reply_byte0, exp_b.reply_byte1,
                     exp_b.reply_byte2, exp_b.payload, exp_b.last,
                     " got kind %0d b %h %h %h payload %h last %b", got.kind,
                     got.reply_byte0, got.reply_byte1, got.reply_byte2, got.payload,
                     got.last);
    endtask

    // output side: check each taken beat, then pick the next stall
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_answers.size() == 0) begin
                report_miss("unexpected beat", '0, out_data);
            end else begin
                want = pending_answers.pop_front();
                beats_checked++;
                if (!want.last)
                    notes_checked++;
                if (out_data.kind !== want.kind || out_data.reply_byte0 !== want.reply_byte0
                        || out_data.reply_byte1 !== want.reply_byte1
                        || out_data.reply_byte2 !== want.reply_byte2
                        || out_data.payload !== want.payload || out_data.last !== want.last)
                    report_miss("beat mismatch", want, out_data);
            end
        end
        if (no_idle) begin
            out_stall <= 1'b0;
            out_hold  <= 0;
        end else if (out_hold != 0) begin
            out_stall <= 1'b1;
            out_hold  <= out_hold - 1;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            out_stall <= 1'b1;
            out_hold  <= $urandom_range(0, 11);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // stimulus
    initial begin
        int p;
        int i;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_EAR_SIDE;
        cfg_wdata <= 64'h0;
        in_valid  <= 1'b0;
        in_data   <= '0;

        cfg_side     = 1'b0;
        cfg_addr     = 48'h0;
        cfg_ver      = 64'h0;
        cfg_img      = 32'h0;
        peer_addr    = 48'h010000151413;
        peer_ver     = 64'h0;
        case_ver     = 64'h0;
        addr_off     = 3'd0;
        peer_ver_off = 3'd0;
        case_ver_off = 3'd0;
        need_up      = 1'b0;

        // left side, registers at reset
        dir_tab = '{
            '{mk(EAR_LEFT, CMD_STATUS, PT_START, 8'h00, 8'h00, 8'hFF, 2'd3), 1'b1, 1'b0,
              {EAR_LEFT, CMD_STATUS, PT_START, 8'hD0, 8'hFF}},
            '{mk(EAR_LEFT, CMD_STATUS, PT_RESEND, 8'hFF, 8'hFF, 8'h00, 2'd0), 1'b1, 1'b0,
              {EAR_LEFT, CMD_STATUS, PT_RESEND, 8'h10, 8'h00}},
            '{mk(EAR_LEFT, CMD_OWN_BATT, PT_DATA, 8'h00, 8'h00, 8'hFF, 2'd0), 1'b1, 1'b0,
              {EAR_LEFT, CMD_OWN_BATT, PT_DATA, 8'hFF, 8'h00}},
            '{mk(EAR_LEFT, CMD_FIRST_UNUSED, PT_START, 8'h00, 8'h00, 8'h00, 2'd0), 1'b1,
              1'b0, 24'h0},
            '{mk(EAR_LEFT, CMD_LAST_UNUSED, PT_RESEND, 8'hFF, 8'hFF, 8'hFF, 2'd3), 1'b1,
              1'b0, 24'h0},
            '{mk(EAR_NONE, CMD_STATUS, PT_START, 8'h00, 8'h00, 8'h00, 2'd0), 1'b1, 1'b1,
              24'h0},
            '{mk(EAR_BOTH, CMD_STATUS, PT_RESEND, 8'hFF, 8'hFF, 8'hFF, 2'd3), 1'b1, 1'b1,
              24'h0},
            '{mk(EAR_RIGHT, CMD_PEER_ADDR, PT_DATA, 8'hFF, 8'hFF, 8'h00, 2'd0), 1'b1, 1'b1,
              24'h0},
            '{mk(EAR_LEFT, CMD_TEST, PT_DATA, 8'hFF, 8'hFF, 8'h00, 2'd0), 1'b1, 1'b0,
              {EAR_LEFT, CMD_TEST, PT_DATA, 16'h0000}},
            '{mk(EAR_LEFT, CMD_GET_ADDR, PT_DATA, 8'h00, 8'h00, 8'h00, 2'd0), 1'b1, 1'b0,
              {EAR_LEFT, CMD_GET_ADDR, PT_DATA, 16'h0000}},
            '{mk(EAR_LEFT, CMD_GET_ADDR, PT_DATA, 8'hFF, 8'h00, 8'h00, 2'd0), 1'b1, 1'b0,
              {EAR_LEFT, CMD_GET_ADDR, PT_DATA, 16'h0000}},
            '{mk(EAR_LEFT, CMD_PEER_ADDR, PT_END, 8'h00, 8'h00, 8'h00, 2'd0), 1'b0, 1'b0,
              24'h0},
            '{mk(EAR_LEFT, CMD_PEER_ADDR, PT_START, 8'h00, 8'h00, 8'h00, 2'd0), 1'b0, 1'b0,
              24'h0},
            '{mk(EAR_LEFT, CMD_PEER_ADDR, PT_DATA, 8'hAA, 8'h55, 8'h00, 2'd0), 1'b0, 1'b0,
              24'h0},
            '{mk(EAR_LEFT, CMD_PEER_ADDR, PT_DATA, 8'hFF, 8'hFF, 8'h00, 2'd0), 1'b0, 1'b0,
              24'h0},
            '{mk(EAR_LEFT, CMD_PEER_ADDR, PT_DATA, 8'h00, 8'h00, 8'h00, 2'd0), 1'b0, 1'b0,
              24'h0},
            '{mk(EAR_LEFT, CMD_PEER_ADDR, PT_DATA, 8'h12, 8'h34, 8'h00, 2'd0), 1'b0, 1'b0,
              24'h0},
            '{mk(EAR_LEFT, CMD_PEER_ADDR, PT_END, 8'h00, 8'h00, 8'h00, 2'd0), 1'b0, 1'b0,
              24'h0},
            '{mk(EAR_LEFT, CMD_CASE_VER, PT_DATA, 8'hFF, 8'hFF, 8'h00, 2'd0), 1'b0, 1'b0,
              24'h0},
            '{mk(EAR_LEFT, CMD_CASE_VER, PT_END, 8'h00, 8'h00, 8'h00, 2'd0), 1'b0, 1'b0,
              24'h0},
            '{mk(EAR_LEFT, CMD_PEER_VER, PT_DATA, 8'h01, 8'h80, 8'h00, 2'd0), 1'b0, 1'b0,
              24'h0},
            '{mk(EAR_LEFT, CMD_PEER_VER, PT_END, 8'h00, 8'h00, 8'h00, 2'd0), 1'b0, 1'b0,
              24'h0},
            '{mk(EAR_LEFT, CMD_EVENT, PT_DATA, 8'hB0, 8'h85, 8'h00, 2'd0), 1'b0, 1'b0,
              24'h0},
            '{mk(EAR_LEFT, CMD_EVENT, PT_DATA, 8'h40, 8'h8C, 8'h00, 2'd0), 1'b0, 1'b0,
              24'h0},
            '{mk(EAR_LEFT, CMD_CASE_BATT, PT_DATA, 8'h5A, 8'h00, 8'h00, 2'd0), 1'b0, 1'b0,
              24'h0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (i = 0; i < N_DIR; i++)
            send(dir_tab[i].pk, dir_tab[i].typed, dir_tab[i].silent, dir_tab[i].reply);
        send(mk(EAR_LEFT, CMD_UPGRADE, PT_END, 8'h00, 8'h00, 8'h00, 2'd0));
        in_valid <= 1'b0;
        settle();

        // random phases, one register setting each; the last runs with no idling
        for (p = 0; p < N_SETTINGS; p++) begin
            case (p)
                0: begin
                    cfg_write(CFG_EAR_SIDE, 64'h1);
                    cfg_write(CFG_LOCAL_ADDR, 64'h0000_FFFF_FFFF_FFFF);
                    cfg_write(CFG_LOCAL_VER, 64'hFFFF_FFFF_FFFF_FFFF);
                    cfg_write(CFG_IMAGE_VER, 64'h0000_0000_FFFF_FFFF);
                end
                1: begin
                    cfg_write(CFG_EAR_SIDE, 64'h0);
                    cfg_write(CFG_LOCAL_ADDR, 64'h0);
                    cfg_write(CFG_LOCAL_VER, 64'h0);
                    cfg_write(CFG_IMAGE_VER, 64'h0);
                end
                default: begin
                    cfg_write(CFG_EAR_SIDE, 64'($urandom_range(0, 1)));
                    cfg_write(CFG_LOCAL_ADDR, {16'h0, 16'($urandom), 32'($urandom)});
                    cfg_write(CFG_LOCAL_VER, {32'($urandom), 32'($urandom)});
                    cfg_write(CFG_IMAGE_VER, {32'h0, 32'($urandom)});
                end
            endcase
            cfg_we    <= 1'b0;
            no_idle   = (p == N_SETTINGS - 1);
            own_items = 0;
            while (own_items < PER_PHASE)
                run_sequence();
            in_valid <= 1'b0;
            settle();
        end

        if (pending_answers.size() != 0)
            errors += pending_answers.size();
        $display("ran %0d packets over %0d register settings plus a directed table",
                 all_items, N_SETTINGS);
        $display("checked %0d result beats, %0d of them notifications; %0d mismatches",
                 beats_checked, notes_checked, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
